>>> sv/far_pkg.sv
`timescale 1ns / 1ps
// Package for the fraction arithmetic and reduction block.
// Holds operation and status codes and the controller/datapath structs.
// No dependencies.
package far_pkg;

  // Operation codes carried in the kind field.
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DEN_IN   = 2'd1;
  localparam logic [1:0] ST_DEN_OUT  = 2'd2;

  // Width of the wrapped numerator and denominator.
  localparam int unsigned VAL_W = 32;

  // Which cross product the shared multiplier forms.
  typedef enum logic [1:0] {
    MIDX_FIRST  = 2'd0,
    MIDX_SECOND = 2'd1,
    MIDX_DENOM  = 2'd2
  } far_midx_t;

  // Operand pair handed to the divider.
  typedef enum logic [1:0] {
    DSEL_EUC = 2'd0,
    DSEL_NUM = 2'd1,
    DSEL_DEN = 2'd2
  } far_dsel_t;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    far_midx_t  mul_idx;
    logic       combine;
    logic       euc_init;
    logic       div_start;
    far_dsel_t  div_sel;
    logic       euc_update;
    logic       qn_load;
    logic       qd_load;
    logic       out_load;
    logic [1:0] out_status;
  } far_cmd_t;

  typedef struct packed {
    logic den_in_zero;
    logic den_out_zero;
    logic euc_done;
    logic div_done;
  } far_sts_t;

endpackage

>>> sv/far_in_if.sv
`timescale 1ns / 1ps
// Input channel of the fraction block: valid/ready and two fractions.
// Depends on nothing.
interface far_in_if #(
  parameter int OPERAND_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic signed [OPERAND_WIDTH-1:0] num_a;
  logic signed [OPERAND_WIDTH-1:0] den_a;
  logic signed [OPERAND_WIDTH-1:0] num_b;
  logic signed [OPERAND_WIDTH-1:0] den_b;

  modport source (output valid, kind, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, kind, num_a, den_a, num_b, den_b, output ready);
endinterface

>>> sv/far_out_if.sv
`timescale 1ns / 1ps
// Result channel of the fraction block: valid/ready and the reduced fraction.
// Depends on nothing.
interface far_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] num_out;
  logic signed [31:0] den_out;
  logic [1:0]         status;

  modport source (output valid, num_out, den_out, status, input ready);
  modport sink   (input valid, num_out, den_out, status, output ready);
endinterface

>>> sv/far_div.sv
`timescale 1ns / 1ps
// Sequential signed divider with truncating quotient and remainder.
// Aligns the divisor to the dividend, then restores one bit per cycle.
// Depends on far_pkg.
module far_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [far_pkg::VAL_W-1:0] dividend,
  input  logic signed [far_pkg::VAL_W-1:0] divisor,
  output logic                            done,
  output logic signed [far_pkg::VAL_W-1:0] quo,
  output logic signed [far_pkg::VAL_W-1:0] rem
);
  import far_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_ALIGN = 3'b010,
    PH_SUB   = 3'b100
  } far_div_ph_t;

  far_div_ph_t      phase_r, phase_nxt;
  logic             done_r, done_nxt;
  logic             sa_r, sa_nxt;
  logic             sq_r, sq_nxt;
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [VAL_W:0]   dv_r, dv_nxt;
  logic [VAL_W-1:0] q_r, q_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [VAL_W-1:0] ua, ub;
  logic             ge;

  // Magnitudes; the most negative value maps to 2^31, which still fits.
  assign ua = dividend[VAL_W-1] ? (~$unsigned(dividend) + 32'd1) : $unsigned(dividend);
  assign ub = divisor[VAL_W-1]  ? (~$unsigned(divisor) + 32'd1)  : $unsigned(divisor);
  assign ge = (dv_r <= {1'b0, rem_r});

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    sa_nxt    = sa_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    dv_nxt    = dv_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          sa_nxt    = dividend[VAL_W-1];
          sq_nxt    = dividend[VAL_W-1] ^ divisor[VAL_W-1];
          rem_nxt   = ua;
          dv_nxt    = {1'b0, ub};
          q_nxt     = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_ALIGN;
        end
      end
      PH_ALIGN: begin
        if ({dv_r, 1'b0} <= {2'b00, rem_r}) begin
          dv_nxt  = {dv_r[VAL_W-1:0], 1'b0};
          cnt_nxt = cnt_r + 5'd1;
        end else begin
          phase_nxt = PH_SUB;
        end
      end
      PH_SUB: begin
        if (ge) begin
          rem_nxt = rem_r - dv_r[VAL_W-1:0];
        end
        q_nxt = {q_r[VAL_W-2:0], ge};
        if (cnt_r == 5'd0) begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end else begin
          dv_nxt  = dv_r >> 1;
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sa_r  <= sa_nxt;
    sq_r  <= sq_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  // The quotient sign follows both operands, the remainder sign the dividend.
  assign done = done_r;
  assign quo  = sq_r ? $signed(~q_r + 32'd1) : $signed(q_r);
  assign rem  = sa_r ? $signed(~rem_r + 32'd1) : $signed(rem_r);

  // When a division finishes, the divisor is back at its magnitude and
  // the remainder magnitude lies below it.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < dv_r))
    else $error("divider remainder not below divisor");

  a_done_after_sub: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(phase_r == PH_SUB))
    else $error("divider done without a final subtract step");

endmodule

>>> sv/far_dp.sv
`timescale 1ns / 1ps
// Datapath of the fraction block: operand registers, shared multiplier,
// cross-product combine, Euclid registers and the sequential divider.
// Depends on far_pkg and far_div.
module far_dp #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  far_pkg::far_cmd_t                cmd,
  output far_pkg::far_sts_t                sts,
  input  logic [1:0]                       kind,
  input  logic signed [OPERAND_WIDTH-1:0]  num_a,
  input  logic signed [OPERAND_WIDTH-1:0]  den_a,
  input  logic signed [OPERAND_WIDTH-1:0]  num_b,
  input  logic signed [OPERAND_WIDTH-1:0]  den_b,
  output logic signed [far_pkg::VAL_W-1:0] num_out,
  output logic signed [far_pkg::VAL_W-1:0] den_out,
  output logic [1:0]                       status
);
  import far_pkg::*;

  localparam int PW = 2 * OPERAND_WIDTH;

  logic [1:0]                      kind_r;
  logic signed [OPERAND_WIDTH-1:0] a_r, da_r, b_r, db_r;
  logic signed [OPERAND_WIDTH-1:0] mx, my;
  logic signed [PW-1:0]            prod;
  logic signed [63:0]              prod_ext;
  logic signed [VAL_W-1:0]         p0_r, p1_r, p2_r;
  logic signed [VAL_W-1:0]         n_r, d_r, n_nxt, d_nxt;
  logic signed [VAL_W-1:0]         x_r, y_r;
  logic signed [VAL_W-1:0]         qn_r, qd_r;
  logic signed [VAL_W-1:0]         num_out_r, den_out_r;
  logic [1:0]                      status_r;
  logic signed [VAL_W-1:0]         div_a, div_b, div_q, div_rem;
  logic                            div_done;

  always_comb begin
    case (cmd.mul_idx)
      MIDX_FIRST: begin
        mx = a_r;
        my = (kind_r == KIND_MUL) ? b_r : db_r;
      end
      MIDX_SECOND: begin
        mx = b_r;
        my = da_r;
      end
      default: begin
        mx = da_r;
        my = db_r;
      end
    endcase
  end

  // Products wrap to 32 bits; a sign extension covers narrow operands.
  assign prod     = mx * my;
  assign prod_ext = 64'(prod);

  always_comb begin
    case (kind_r)
      KIND_ADD: n_nxt = p0_r + p1_r;
      KIND_SUB: n_nxt = p0_r - p1_r;
      default:  n_nxt = p0_r;
    endcase
    d_nxt = (kind_r == KIND_DIV) ? p1_r : p2_r;
  end

  always_comb begin
    case (cmd.div_sel)
      DSEL_EUC: begin
        div_a = x_r;
        div_b = y_r;
      end
      DSEL_NUM: begin
        div_a = n_r;
        div_b = x_r;
      end
      default: begin
        div_a = d_r;
        div_b = x_r;
      end
    endcase
  end

  far_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= kind;
      a_r    <= num_a;
      da_r   <= den_a;
      b_r    <= num_b;
      db_r   <= den_b;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_idx)
        MIDX_FIRST:  p0_r <= prod_ext[VAL_W-1:0];
        MIDX_SECOND: p1_r <= prod_ext[VAL_W-1:0];
        default:     p2_r <= prod_ext[VAL_W-1:0];
      endcase
    end
    if (cmd.combine) begin
      n_r <= n_nxt;
      d_r <= d_nxt;
    end
    if (cmd.euc_init) begin
      x_r <= n_r;
      y_r <= d_r;
    end else if (cmd.euc_update) begin
      x_r <= y_r;
      y_r <= div_rem;
    end
    if (cmd.qn_load) begin
      qn_r <= div_q;
    end
    if (cmd.qd_load) begin
      qd_r <= div_q;
    end
    if (cmd.out_load) begin
      status_r <= cmd.out_status;
      if (cmd.out_status == ST_OK) begin
        num_out_r <= qn_r;
        den_out_r <= qd_r;
      end else begin
        num_out_r <= '0;
        den_out_r <= '0;
      end
    end
  end

  assign sts.den_in_zero  = (da_r == '0) || (db_r == '0);
  assign sts.den_out_zero = (d_r == '0);
  assign sts.euc_done     = (y_r == '0);
  assign sts.div_done     = div_done;

  assign num_out = num_out_r;
  assign den_out = den_out_r;
  assign status  = status_r;

  // The divisor divides the denominator exactly, so a good result never
  // carries a zero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && (cmd.out_status == ST_OK)) |=> (den_out_r != '0))
    else $error("reduced denominator is zero on a good result");

endmodule

>>> sv/far_ctrl.sv
`timescale 1ns / 1ps
// Controller of the fraction block: sequences the multiplies, the Euclid
// loop and the two final divisions, and owns both channel handshakes.
// Depends on far_pkg.
module far_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output far_pkg::far_cmd_t cmd,
  input  far_pkg::far_sts_t sts
);
  import far_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_MUL0      = 11'b000_0000_0010,
    S_MUL1      = 11'b000_0000_0100,
    S_MUL2      = 11'b000_0000_1000,
    S_COMB      = 11'b000_0001_0000,
    S_EVAL      = 11'b000_0010_0000,
    S_EUC_TEST  = 11'b000_0100_0000,
    S_EUC_WAIT  = 11'b000_1000_0000,
    S_DIVN_WAIT = 11'b001_0000_0000,
    S_DIVD_WAIT = 11'b010_0000_0000,
    S_FINISH    = 11'b100_0000_0000
  } far_state_t;

  far_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] fin_status_r, fin_status_nxt;

  always_comb begin
    state_nxt      = state_r;
    fin_status_nxt = fin_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mul_idx    = MIDX_FIRST;
    cmd.div_sel    = DSEL_EUC;
    cmd.out_status = fin_status_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_idx = MIDX_FIRST;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_idx = MIDX_SECOND;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_idx = MIDX_DENOM;
        state_nxt   = S_COMB;
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        if (sts.den_in_zero) begin
          fin_status_nxt = ST_DEN_IN;
          state_nxt      = S_FINISH;
        end else if (sts.den_out_zero) begin
          fin_status_nxt = ST_DEN_OUT;
          state_nxt      = S_FINISH;
        end else begin
          cmd.euc_init = 1'b1;
          state_nxt    = S_EUC_TEST;
        end
      end
      S_EUC_TEST: begin
        // Once the second Euclid value reaches zero the first one is the divisor.
        cmd.div_start = 1'b1;
        if (sts.euc_done) begin
          cmd.div_sel = DSEL_NUM;
          state_nxt   = S_DIVN_WAIT;
        end else begin
          cmd.div_sel = DSEL_EUC;
          state_nxt   = S_EUC_WAIT;
        end
      end
      S_EUC_WAIT: begin
        cmd.div_sel = DSEL_EUC;
        if (sts.div_done) begin
          cmd.euc_update = 1'b1;
          state_nxt      = S_EUC_TEST;
        end
      end
      S_DIVN_WAIT: begin
        if (sts.div_done) begin
          cmd.qn_load   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_DEN;
          state_nxt     = S_DIVD_WAIT;
        end
      end
      S_DIVD_WAIT: begin
        cmd.div_sel = DSEL_DEN;
        if (sts.div_done) begin
          cmd.qd_load    = 1'b1;
          fin_status_nxt = ST_OK;
          state_nxt      = S_FINISH;
        end
      end
      S_FINISH: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      fin_status_r <= ST_OK;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      fin_status_r <= fin_status_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result presented without passing the finish state");

  a_den_in_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && sts.den_in_zero) |=> (fin_status_r == ST_DEN_IN))
    else $error("zero input denominator not flagged");

endmodule

>>> sv/fraction_arith_reduce.sv
`timescale 1ns / 1ps
// Fraction arithmetic with reduction: takes two signed fractions and an
// operation (add, subtract, multiply, divide), forms the cross-product
// numerator and denominator wrapped to 32 bits, finds their divisor with
// Euclid's loop on truncating signed remainders, and returns both values
// divided by it. A zero input denominator returns status 1, a zero product
// denominator status 2, each with a zeroed fraction. One transaction is
// worked on at a time: the shared multiplier forms the three products in
// turn, a combine state and a check state follow, then every Euclid step
// and the two final divisions run through one shift-subtract divider
// (the second final division starts in the cycle the first one ends),
// and the finish state loads the output register. A finished result
// waits in the output register while the next transaction is accepted.
// Depends on far_pkg, far_in_if, far_out_if, far_ctrl and far_dp.
module fraction_arith_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  far_in_if.sink    in_chan,
  far_out_if.source out_chan
);
  import far_pkg::*;

  far_cmd_t cmd;
  far_sts_t sts;

  far_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  far_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .kind    (in_chan.kind),
    .num_a   (in_chan.num_a),
    .den_a   (in_chan.den_a),
    .num_b   (in_chan.num_b),
    .den_b   (in_chan.den_b),
    .num_out (out_chan.num_out),
    .den_out (out_chan.den_out),
    .status  (out_chan.status)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for fraction_arith_reduce: directed and random fraction operations,
// checked against an in-bench predictor through a small scoreboard class.
// Depends on far_pkg, far_in_if, far_out_if and the fraction_arith_reduce RTL.
module tb;
  import far_pkg::*;

  localparam int OPW        = 16;
  localparam int RAND_ITEMS = 700;
  localparam int CALM_ITEMS = 120;
  localparam int PAUSE_AT   = 300;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 400;

  typedef struct packed {
    logic [1:0]            kind;
    logic signed [OPW-1:0] num_a;
    logic signed [OPW-1:0] den_a;
    logic signed [OPW-1:0] num_b;
    logic signed [OPW-1:0] den_b;
  } frac_op_t;

  typedef struct packed {
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic [1:0]         status;
  } frac_res_t;

  class fraction_scoreboard;
    frac_res_t pending_results[$];
    int        fault_count;
    int        reported;

    static function longint wrap32(longint v);
      int t;
      t = int'(v);
      return t;
    endfunction

    // Cross products wrapped to 32 bits, then Euclid's loop with a truncating
    // remainder, so the divisor can come out negative.
    static function frac_res_t reduce_fraction(frac_op_t op);
      longint    a, da, b, db, n, d, x, y, r, g;
      frac_res_t res;
      res = '0;
      a  = longint'($signed(op.num_a));
      da = longint'($signed(op.den_a));
      b  = longint'($signed(op.num_b));
      db = longint'($signed(op.den_b));
      if (da == 0 || db == 0) begin
        res.status = ST_DEN_IN;
        return res;
      end
      case (op.kind)
        KIND_ADD: begin
          n = a * db + b * da;
          d = da * db;
        end
        KIND_SUB: begin
          n = a * db - b * da;
          d = da * db;
        end
        KIND_MUL: begin
          n = a * b;
          d = da * db;
        end
        default: begin
          n = a * db;
          d = b * da;
        end
      endcase
      n = wrap32(n);
      d = wrap32(d);
      if (d == 0) begin
        res.status = ST_DEN_OUT;
        return res;
      end
      x = n;
      y = d;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      g = (x == 0) ? 1 : x;
      res.num    = 32'(wrap32(n / g));
      res.den    = 32'(wrap32(d / g));
      res.status = ST_OK;
      return res;
    endfunction

    function void note_input(frac_op_t op);
      pending_results.push_back(reduce_fraction(op));
    endfunction

    function void check_result(frac_res_t got);
      frac_res_t want;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: unexpected result num=%0d den=%0d status=%0d",
                   got.num, got.den, got.status);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.num !== want.num || got.den !== want.den || got.status !== want.status) begin
        fault_count++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: result mismatch: expected %0d/%0d status %0d, got %0d/%0d status %0d",
                   want.num, want.den, want.status, got.num, got.den, got.status);
        end
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   idle_cycles;

  fraction_scoreboard sb = new;

  far_in_if #(.OPERAND_WIDTH(OPW)) in_chan ();
  far_out_if                       out_chan ();

  fraction_arith_reduce #(.OPERAND_WIDTH(OPW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Both channels are sampled at the rising edge, before the block's own
  // updates of that edge land.
  always @(posedge clk) begin : monitor
    frac_op_t  seen_op;
    frac_res_t seen_res;
    bit        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_chan.valid && in_chan.ready) begin
        seen_op = '{in_chan.kind, in_chan.num_a, in_chan.den_a, in_chan.num_b, in_chan.den_b};
        sb.note_input(seen_op);
        moved = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        seen_res = '{out_chan.num_out, out_chan.den_out, out_chan.status};
        sb.check_result(seen_res);
        moved = 1'b1;
      end
      if (moved) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, always ready once the run calms down.
  initial begin
    out_chan.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic drive_op(frac_op_t op);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind  <= op.kind;
    in_chan.num_a <= op.num_a;
    in_chan.den_a <= op.den_a;
    in_chan.num_b <= op.num_b;
    in_chan.den_b <= op.den_b;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic fraction_op(logic [1:0] k, int a, int da, int b, int db);
    frac_op_t op;
    op = '{k, OPW'(a), OPW'(da), OPW'(b), OPW'(db)};
    drive_op(op);
  endtask

  task automatic wait_results_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic signed [OPW-1:0] corner_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'h0001;
      5: return 16'h7FFF;
      default: return OPW'($urandom);
    endcase
  endfunction

  function automatic logic signed [OPW-1:0] small_value(bit nonzero);
    int v;
    v = nonzero ? $urandom_range(1, 20) : $urandom_range(0, 20);
    if ($urandom_range(0, 1) == 1) v = -v;
    return OPW'(v);
  endfunction

  function automatic frac_op_t random_op();
    frac_op_t op;
    int       pick;
    pick    = $urandom_range(0, 99);
    op.kind = 2'($urandom_range(0, 3));
    if (pick < 45) begin
      op.num_a = small_value(1'b0);
      op.den_a = small_value(1'b1);
      op.num_b = small_value(1'b0);
      op.den_b = small_value(1'b1);
    end else if (pick < 75) begin
      op.num_a = OPW'($urandom);
      op.den_a = OPW'($urandom);
      op.num_b = OPW'($urandom);
      op.den_b = OPW'($urandom);
    end else if (pick < 87) begin
      op.num_a = corner_value();
      op.den_a = corner_value();
      op.num_b = corner_value();
      op.den_b = corner_value();
    end else if (pick < 94) begin
      // Zero input denominator on one or both sides.
      op.num_a = OPW'($urandom);
      op.num_b = OPW'($urandom);
      op.den_a = ($urandom_range(0, 1) == 1) ? '0 : OPW'($urandom);
      op.den_b = ($urandom_range(0, 1) == 1) ? '0 : OPW'($urandom);
      if (op.den_a != 0 && op.den_b != 0) op.den_b = '0;
    end else begin
      // Division by a zero fraction.
      op.kind  = KIND_DIV;
      op.num_a = small_value(1'b0);
      op.den_a = small_value(1'b1);
      op.num_b = '0;
      op.den_b = OPW'($urandom);
      if (op.den_b == 0) op.den_b = 16'sd1;
    end
    return op;
  endfunction

  initial begin
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.kind  = KIND_ADD;
    in_chan.num_a = '0;
    in_chan.den_a = '0;
    in_chan.num_b = '0;
    in_chan.den_b = '0;
    idle_cycles   = 0;
    calm          = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    fraction_op(KIND_ADD, 1, 2, 1, 3);
    fraction_op(KIND_SUB, 1, 2, 1, 2);
    fraction_op(KIND_MUL, -3, 4, 2, 5);
    fraction_op(KIND_DIV, 3, 4, 5, 6);
    fraction_op(KIND_ADD, 7, 0, 1, 3);
    fraction_op(KIND_SUB, 7, 5, 1, 0);
    fraction_op(KIND_DIV, 7, 0, 1, 0);
    fraction_op(KIND_DIV, 3, 4, 0, 5);
    // A product denominator of minus one forces a remainder by minus one.
    fraction_op(KIND_ADD, 5, -1, 3, 1);
    fraction_op(KIND_ADD, -32768, -32768, -32768, -32768);
    fraction_op(KIND_MUL, -32768, 32767, -32768, 32767);
    fraction_op(KIND_SUB, 32767, -32768, -32768, 32767);
    fraction_op(KIND_DIV, -32768, 1, -1, 1);
    fraction_op(KIND_MUL, 32767, 32767, 32767, 32767);
    fraction_op(KIND_DIV, 0, -32768, -32768, -1);
    fraction_op(KIND_ADD, 0, 1, 0, 1);
    fraction_op(KIND_MUL, -1, -1, -1, -1);
    fraction_op(KIND_ADD, 32767, 1, 32767, 1);
    fraction_op(KIND_SUB, -32768, -1, 32767, 1);
    fraction_op(KIND_DIV, 1, -32768, -32768, 32767);
    fraction_op(KIND_DIV, 5, -32768, 0, -32768);
    fraction_op(KIND_MUL, 0, -32768, 32767, -1);
    fraction_op(KIND_SUB, 12, 18, -8, 27);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == PAUSE_AT) begin
        in_chan.valid <= 1'b0;
        wait_results_drained();
      end
      if (i == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      drive_op(random_op());
    end
    in_chan.valid <= 1'b0;

    wait_results_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.fault_count += sb.pending();
      $display("ERROR: %0d results never arrived", sb.pending());
    end
    if (sb.fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
